// ----- rtl/selective_repeat_receive_window_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the selective-repeat receive window
// Concurrent checks are active in simulation and compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_TOP_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SRRW_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srrw: same-cycle check failed");
// Next-cycle implication.
`define SRRW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srrw: next-cycle check failed");
`else
`define SRRW_ASSERT_IMPLIES(lbl, ante, cons)
`define SRRW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/srrw_pkg.sv -----
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared types, codes and constants of the selective-repeat receive window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srrw_pkg;

  localparam int DEF_WINDOW_SLOTS = 8;

  localparam logic [15:0] SEQ_STEP        = 16'd255;
  localparam logic [3:0]  FIN_REPEATS_RST = 4'd5;

  // input kinds
  localparam logic KIND_PACKET  = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  // packet flags
  localparam logic [2:0] FLG_DATA   = 3'd0;
  localparam logic [2:0] FLG_RESET  = 3'd1;
  localparam logic [2:0] FLG_FINISH = 3'd2;

  // result actions
  localparam logic [2:0] ACT_STORE   = 3'd0;
  localparam logic [2:0] ACT_DELIVER = 3'd1;
  localparam logic [2:0] ACT_ACK     = 3'd2;
  localparam logic [2:0] ACT_RESET   = 3'd3;
  localparam logic [2:0] ACT_FINISH  = 3'd4;
  localparam logic [2:0] ACT_CLOSED  = 3'd5;

  // configuration register indexes
  localparam logic REG_OWN_CONN    = 1'b0;
  localparam logic REG_FIN_REPEATS = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] conn_id;
    logic [15:0] seq_number;
    logic [2:0]  flags;
    logic [7:0]  data_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] peer_conn;
    logic [15:0] ack_number;
    logic [2:0]  slot;
    logic [7:0]  length;
    logic        last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       search_step;
    logic       store;
    logic       deliver;
    logic       fin_load;
    logic       fin_step;
    logic       set_finished;
    logic       emit;
    logic [2:0] action;
    logic       last;
  } srrw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic finished;
    logic timeout;
    logic own_reset;
    logic foreign;
    logic finish_req;
    logic data_req;
    logic seq_match;
    logic search_last;
    logic slot_taken;
    logic head_present;
    logic fin_last;
    logic out_free;
  } srrw_status_t;

endpackage

// ----- rtl/srrw_ctrl.sv -----
// ----------------------------------------------------------------------------
// srrw_ctrl
// Sequencer: decodes the held item and steps through search, store,
// delivery and acknowledgement, or through the finish results, one result per cycle at most.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srrw_ctrl
  import srrw_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  srrw_status_t status,
  output srrw_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_SEARCH  = 3'd2;
  localparam logic [2:0] S_STORE   = 3'd3;
  localparam logic [2:0] S_DELIVER = 3'd4;
  localparam logic [2:0] S_ACK     = 3'd5;
  localparam logic [2:0] S_FIN     = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.finished) begin
          state_nxt = S_IDLE;
        end else if (status.timeout) begin
          if (status.out_free) begin
            cmd.emit   = 1'b1;
            cmd.action = ACT_ACK;
            cmd.last   = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else if (status.own_reset) begin
          if (status.out_free) begin
            cmd.emit         = 1'b1;
            cmd.action       = ACT_CLOSED;
            cmd.last         = 1'b1;
            cmd.set_finished = 1'b1;
            state_nxt        = S_IDLE;
          end
        end else if (status.foreign) begin
          if (status.out_free) begin
            cmd.emit   = 1'b1;
            cmd.action = ACT_RESET;
            cmd.last   = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else if (status.finish_req) begin
          cmd.fin_load = 1'b1;
          state_nxt    = S_FIN;
        end else if (status.data_req) begin
          state_nxt = S_SEARCH;
        end else begin
          state_nxt = S_ACK;
        end
      end
      S_SEARCH: begin
        if (status.seq_match) begin
          state_nxt = S_STORE;
        end else if (status.search_last) begin
          state_nxt = S_ACK;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      S_STORE: begin
        if (status.slot_taken) begin
          state_nxt = S_DELIVER;
        end else if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.action = ACT_STORE;
          cmd.store  = 1'b1;
          state_nxt  = S_DELIVER;
        end
      end
      S_DELIVER: begin
        if (!status.head_present) begin
          state_nxt = S_ACK;
        end else if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.action  = ACT_DELIVER;
          cmd.deliver = 1'b1;
        end
      end
      S_ACK: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.action = ACT_ACK;
          cmd.last   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.action   = ACT_FINISH;
          cmd.last     = status.fin_last;
          cmd.fin_step = 1'b1;
          if (status.fin_last) begin
            cmd.set_finished = 1'b1;
            state_nxt        = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/srrw_dp.sv -----
// ----------------------------------------------------------------------------
// srrw_dp
// Window state, configuration registers, sequence search and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srrw_dp
  import srrw_pkg::*;
#(
  parameter int WINDOW_SLOTS = DEF_WINDOW_SLOTS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  in_item_t     in_data,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  srrw_cmd_t    cmd,
  output srrw_status_t status,
  output logic         out_valid,
  input  logic         out_stall,
  output out_item_t    out_data
);

  localparam int          SW      = $clog2(WINDOW_SLOTS);
  localparam logic [SW:0] W_EXT   = (SW + 1)'(WINDOW_SLOTS);
  localparam logic [SW-1:0] W_LAST = SW'(WINDOW_SLOTS - 1);
  localparam logic [5:0]  FIN_CAP = 6'(WINDOW_SLOTS + 2);

  in_item_t        in_r;
  logic [31:0]     own_conn_r;
  logic [3:0]      fin_rep_r;
  logic [15:0]     pos_r, pos_nxt;
  logic [WINDOW_SLOTS-1:0] present_r;
  logic [7:0]      len_r [WINDOW_SLOTS];
  logic [SW-1:0]   head_r, head_nxt;
  logic            finished_r;
  logic [15:0]     acc_r;
  logic [SW-1:0]   idx_r;
  logic [3:0]      fin_cnt_r, fin_init;
  logic            out_valid_r;
  out_item_t       out_r, out_nxt;

  logic [SW:0]     slot_sum;
  logic [SW-1:0]   store_slot;
  logic [7:0]      head_len;
  logic [SW+2:0]   slot_wide;

  // physical slot of the matched offset, wrapped once
  assign slot_sum   = {1'b0, head_r} + {1'b0, idx_r};
  assign store_slot = (slot_sum >= W_EXT) ? SW'(slot_sum - W_EXT) : slot_sum[SW-1:0];
  assign head_len   = len_r[head_r];
  assign head_nxt   = (head_r == W_LAST) ? '0 : head_r + 1'b1;
  assign pos_nxt    = pos_r + {8'd0, head_len};

  always_comb begin
    if (fin_rep_r == 4'd0) begin
      fin_init = 4'd1;
    end else if ({2'b00, fin_rep_r} > FIN_CAP) begin
      fin_init = FIN_CAP[3:0];
    end else begin
      fin_init = fin_rep_r;
    end
  end

  assign status.finished     = finished_r;
  assign status.timeout      = (in_r.kind == KIND_TIMEOUT);
  assign status.own_reset    = (in_r.flags == FLG_RESET) && (in_r.conn_id == own_conn_r);
  assign status.foreign      = (in_r.conn_id != 32'd0) && (in_r.conn_id != own_conn_r);
  assign status.finish_req   = (in_r.flags == FLG_FINISH);
  assign status.data_req     = (in_r.flags == FLG_DATA);
  assign status.seq_match    = (acc_r == in_r.seq_number);
  assign status.search_last  = (idx_r == W_LAST);
  assign status.slot_taken   = present_r[store_slot];
  assign status.head_present = present_r[head_r];
  assign status.fin_last     = (fin_cnt_r == 4'd1);
  assign status.out_free     = !out_valid_r || !out_stall;

  always_comb begin
    out_nxt        = '0;
    out_nxt.action = cmd.action;
    out_nxt.last   = cmd.last;
    slot_wide      = '0;
    case (cmd.action)
      ACT_STORE: begin
        slot_wide      = {3'b000, store_slot};
        out_nxt.length = in_r.data_length;
      end
      ACT_DELIVER: begin
        slot_wide      = {3'b000, head_r};
        out_nxt.length = head_len;
      end
      ACT_ACK: begin
        out_nxt.peer_conn  = own_conn_r;
        out_nxt.ack_number = pos_r;
      end
      ACT_RESET:  out_nxt.peer_conn = in_r.conn_id;
      ACT_FINISH: out_nxt.peer_conn = own_conn_r;
      default:    out_nxt.peer_conn = '0;
    endcase
    out_nxt.slot = slot_wide[2:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_conn_r  <= '0;
      fin_rep_r   <= FIN_REPEATS_RST;
      pos_r       <= '0;
      present_r   <= '0;
      head_r      <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_OWN_CONN) begin
          own_conn_r <= cfg_wdata;
        end else begin
          fin_rep_r <= cfg_wdata[3:0];
        end
      end
      if (cmd.store) begin
        present_r[store_slot] <= 1'b1;
      end
      if (cmd.deliver) begin
        present_r[head_r] <= 1'b0;
        pos_r             <= pos_nxt;
        head_r            <= head_nxt;
      end
      if (cmd.set_finished) begin
        finished_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r  <= in_data;
      acc_r <= pos_r;
      idx_r <= '0;
    end else if (cmd.search_step) begin
      acc_r <= acc_r + SEQ_STEP;
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.store) begin
      len_r[store_slot] <= in_r.data_length;
    end
    if (cmd.fin_load) begin
      fin_cnt_r <= fin_init;
    end else if (cmd.fin_step) begin
      fin_cnt_r <= fin_cnt_r - 4'd1;
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/selective_repeat_receive_window_top.sv -----
// ----------------------------------------------------------------------------
// selective_repeat_receive_window_top
// Receiver window of a selective-repeat byte transfer: stores packets, delivers
// them in order and answers with acknowledgements, resets and finishes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): one item is a packet header
//   or a receive timeout. in_stall is high while an item is being worked on;
//   one item is handled at a time.
//   Result channel (out_valid / out_stall / out_data): each item gives zero or
//   more results, the final one flagged by last. A single output register holds
//   a result while out_stall is high; the sequencer waits, and the next item is
//   taken as soon as the last result is in that register.
//   Config port (cfg_we / cfg_index / cfg_wdata): write only while idle.
//   Steps: an item is accepted and decoded; timeout, reset, foreign-id and
//   closed cases end there. A data packet then compares window offsets in
//   turn (up to WINDOW_SLOTS), stores, delivers slots until the head is empty
//   and acks; delivery only follows a match at offset zero. A finish emits
//   its finish packets in turn. Each result stalled by the receiver holds the
//   sequencer for as long as the stall lasts.
//   Reset (synchronous, rst_n low) empties the window, zeroes the position,
//   reopens a closed block and restores the registers to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "selective_repeat_receive_window_top_assert.svh"

module selective_repeat_receive_window_top
  import srrw_pkg::*;
#(
  parameter int WINDOW_SLOTS = DEF_WINDOW_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  srrw_cmd_t    cmd;
  srrw_status_t status;

  // sequencer: decode, search, store, deliver, ack
  srrw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // window state, registers and the result register
  srrw_dp #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Never overwrite a result that the receiver still holds off.
  `SRRW_ASSERT_IMPLIES(a_emit_into_free, cmd.emit, !out_valid || !out_stall)
  // An accepted item keeps the input channel closed in the following cycle.
  `SRRW_ASSERT_NEXT(a_one_item_at_a_time, in_valid && !in_stall, in_stall)
  // Once closed, stay closed until reset.
  `SRRW_ASSERT_NEXT(a_finished_sticky, status.finished, status.finished)
  // Store and deliver never fire together.
  `SRRW_ASSERT_IMPLIES(a_store_xor_deliver, cmd.store, !cmd.deliver)

endmodule

// ----- tb/selective_repeat_receive_window_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receive_window_top_tb
// Self-checking bench for the selective-repeat receive window. A directed table
// covers timeouts, window edges, duplicates, flag mixes, foreign ids and a full
// in-order flush. Random packet streams follow under three idle/stall regimes.
// The run closes the connection with a finish or an own reset at the end. An
// in-bench window model predicts every result and checks it field by field.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window_top_tb;
  import srrw_pkg::*;

  localparam int WIN            = DEF_WINDOW_SLOTS;
  localparam int MAX_RESULTS    = WIN + 2;
  localparam int SETTLE         = 2 * WIN + 6;
  localparam int QUIET_LIMIT    = 4000;
  localparam int RAND_PER_PHASE = 130;

  localparam logic [2:0]  FLG_SYNC     = 3'd4;
  localparam logic [31:0] OWN_DIRECTED = 32'h5A3C_96E1;

  // one row of the directed table; typed rows carry their single result
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } plan_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = REG_OWN_CONN;
  logic [31:0] cfg_wdata = '0;

  // window model: registers, position, slots, head and closed flag
  logic [31:0] own_conn    = '0;
  logic [3:0]  fin_repeats = FIN_REPEATS_RST;
  logic [15:0] next_pos    = '0;
  bit          slot_full [WIN];
  logic [7:0]  slot_len  [WIN];
  int          head        = 0;
  bit          closed      = 1'b0;

  out_item_t predicted_actions[$];   // results still owed by the block, oldest first
  out_item_t step_actions[$];        // results of the item just accepted
  plan_row_t plan[$];

  int send_idle_pct  = 9;
  int recv_stall_pct = 63;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  selective_repeat_receive_window_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic in_item_t pkt(input logic k, input logic [31:0] conn,
                                   input logic [15:0] seq, input logic [2:0] flags,
                                   input logic [7:0] len);
    return '{k, conn, seq, flags, len};
  endfunction

  function automatic out_item_t res(input logic [2:0] act, input logic [31:0] peer,
                                    input logic [15:0] ack, input logic [2:0] slot,
                                    input logic [7:0] len, input logic fin);
    return '{act, peer, ack, slot, len, fin};
  endfunction

  function automatic string describe(input out_item_t r);
    return $sformatf("act=%0d peer=%h ack=%h slot=%0d len=%0d last=%0b",
                     r.action, r.peer_conn, r.ack_number, r.slot, r.length, r.last);
  endfunction

  // count every failure, print only the first ten
  function automatic void flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  task automatic emit(input logic [2:0] act, input logic [31:0] peer,
                      input logic [15:0] ack, input int slot, input logic [7:0] len);
    step_actions.push_back(res(act, peer, ack, 3'(slot), len, 1'b0));
  endtask

  // Advance the window model by one accepted item and collect its results.
  task automatic predict_window_event(input in_item_t it);
    int        reps;
    int        off;
    int        s;
    out_item_t tail;
    step_actions.delete();
    if (!closed) begin
      if (it.kind == KIND_TIMEOUT) begin
        emit(ACT_ACK, own_conn, next_pos, 0, '0);
      end else if (it.flags == FLG_RESET && it.conn_id == own_conn) begin
        closed = 1'b1;
        emit(ACT_CLOSED, '0, '0, 0, '0);
      end else if (it.conn_id != '0 && it.conn_id != own_conn) begin
        emit(ACT_RESET, it.conn_id, '0, 0, '0);
      end else if (it.flags == FLG_FINISH) begin
        reps = (fin_repeats == '0) ? 1 : int'(fin_repeats);
        if (reps > MAX_RESULTS) reps = MAX_RESULTS;
        repeat (reps) emit(ACT_FINISH, own_conn, '0, 0, '0);
        closed = 1'b1;
      end else begin
        if (it.flags == FLG_DATA) begin
          // smallest window offset whose byte position matches wins
          off = -1;
          for (int i = WIN - 1; i >= 0; i--) begin
            if (16'(next_pos + SEQ_STEP * 16'(i)) == it.seq_number) off = i;
          end
          if (off >= 0) begin
            s = (head + off) % WIN;
            if (!slot_full[s]) begin
              slot_full[s] = 1'b1;
              slot_len[s]  = it.data_length;
              emit(ACT_STORE, '0, '0, s, it.data_length);
            end
            while (slot_full[head]) begin
              emit(ACT_DELIVER, '0, '0, head, slot_len[head]);
              next_pos        = next_pos + 16'(slot_len[head]);
              slot_full[head] = 1'b0;
              head            = (head + 1) % WIN;
            end
          end
        end
        emit(ACT_ACK, own_conn, next_pos, 0, '0);
      end
      tail      = step_actions.pop_back();
      tail.last = 1'b1;
      step_actions.push_back(tail);
    end
  endtask

  function automatic bit closes_block(input in_item_t it);
    return it.kind == KIND_PACKET &&
           ((it.flags == FLG_RESET && it.conn_id == own_conn) ||
            (it.flags == FLG_FINISH && (it.conn_id == '0 || it.conn_id == own_conn)));
  endfunction

  // Mostly in-window data, mostly of full length, at offset zero or a random offset; the rest is noise.
  function automatic in_item_t random_event();
    in_item_t    it;
    int          pick;
    int          off;
    logic [31:0] conn;
    pick = $urandom_range(99, 0);
    conn = $urandom_range(1, 0) ? own_conn : 32'd0;
    it   = pkt(KIND_PACKET, conn, 16'($urandom), FLG_DATA, 8'($urandom));
    if (pick < 70) begin
      off = $urandom_range(1, 0) ? 0 : $urandom_range(WIN - 1, 1);
      it.seq_number = next_pos + SEQ_STEP * 16'(off);
      if ($urandom_range(4, 0) != 0) it.data_length = 8'hFF;
    end else if (pick >= 77 && pick < 83) begin
      it.kind    = KIND_TIMEOUT;
      it.conn_id = $urandom;
      it.flags   = 3'($urandom);
    end else if (pick >= 83 && pick < 89) begin
      it.conn_id = $urandom;
      it.flags   = 3'($urandom);
    end else if (pick >= 89) begin
      it.flags = 3'($urandom_range(7, 1));
    end
    return it;
  endfunction

  // Present one item at a falling edge and hold it until the block takes it.
  task automatic offer(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic apply_event(input in_item_t it, input bit typed, input out_item_t want);
    offer(it);
    predict_window_event(it);
    if (typed) predicted_actions.push_back(want);
    else foreach (step_actions[i]) predicted_actions.push_back(step_actions[i]);
  endtask

  // Drop valid, wait for every owed result, then let the sequencer settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_actions.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] own, input logic [3:0] reps);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_OWN_CONN;
    cfg_wdata <= own;
    @(negedge clk);
    cfg_index <= REG_FIN_REPEATS;
    cfg_wdata <= {28'd0, reps};
    @(negedge clk);
    cfg_we      <= 1'b0;
    own_conn    = own;
    fin_repeats = reps;
  endtask

  task automatic row(input in_item_t it);
    plan.push_back('{it, 1'b0, '0});
  endtask

  task automatic row_want(input in_item_t it, input logic [2:0] act,
                          input logic [31:0] peer, input logic [15:0] ack);
    plan.push_back('{it, 1'b1, res(act, peer, ack, 3'd0, 8'd0, 1'b1)});
  endtask

  task automatic random_phase(input int count);
    in_item_t it;
    for (int n = 0; n < count; n++) begin
      // keep the connection open: a close cannot be undone without reset
      do it = random_event(); while (closes_block(it));
      apply_event(it, 1'b0, '0);
      // hold off now and then until the block has answered everything
      if (n % 45 == 44) drain();
    end
  endtask

  // Receiver: redraw the stall at every falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
  end

  // Check each taken result against the oldest prediction; watch for a hang.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && !out_stall) begin
        if (predicted_actions.size() == 0) begin
          flag_error({"unexpected result ", describe(out_data)});
        end else begin
          want = predicted_actions.pop_front();
          if (out_data.action !== want.action || out_data.peer_conn !== want.peer_conn ||
              out_data.ack_number !== want.ack_number || out_data.slot !== want.slot ||
              out_data.length !== want.length || out_data.last !== want.last) begin
            flag_error({"expected ", describe(want), ", got ", describe(out_data)});
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("selective_repeat_receive_window_top: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_item_t   it;
    logic [3:0] last_reps;

    // Hold reset, then release it at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A finish count of zero is allowed by the register and counts as one.
    load_settings(OWN_DIRECTED, 4'd0);

    // Directed table. Typed rows are answers readable at a glance.
    // Timeout right after reset: ack at position zero.
    row_want(pkt(KIND_TIMEOUT, 32'd0, 16'd0, FLG_DATA, 8'd0), ACT_ACK, OWN_DIRECTED, 16'd0);
    // Zero-length packet at the head: store, deliver, position stays.
    row(pkt(KIND_PACKET, 32'd0, 16'd0, FLG_DATA, 8'd0));
    // Out-of-order packet one step ahead, then its duplicate with another length.
    row(pkt(KIND_PACKET, OWN_DIRECTED, 16'd255, FLG_DATA, 8'hFF));
    row(pkt(KIND_PACKET, OWN_DIRECTED, 16'd255, FLG_DATA, 8'h11));
    // Fill the head gap: flush two slots, position moves to 510.
    row(pkt(KIND_PACKET, 32'd0, 16'd0, FLG_DATA, 8'hFF));
    // Last offset of the window, then one past it and a far-off number.
    row(pkt(KIND_PACKET, 32'd0, 16'd2295, FLG_DATA, 8'h01));
    row_want(pkt(KIND_PACKET, 32'd0, 16'd2550, FLG_DATA, 8'h22), ACT_ACK, OWN_DIRECTED, 16'd510);
    row_want(pkt(KIND_PACKET, OWN_DIRECTED, 16'hFFFF, FLG_DATA, 8'hFF),
             ACT_ACK, OWN_DIRECTED, 16'd510);
    // Synchronize and flag mixes only draw an ack.
    row_want(pkt(KIND_PACKET, OWN_DIRECTED, 16'd510, FLG_SYNC, 8'h10),
             ACT_ACK, OWN_DIRECTED, 16'd510);
    row_want(pkt(KIND_PACKET, OWN_DIRECTED, 16'd510, FLG_SYNC | FLG_RESET | FLG_FINISH, 8'h10),
             ACT_ACK, OWN_DIRECTED, 16'd510);
    row_want(pkt(KIND_PACKET, 32'd0, 16'd510, FLG_RESET | FLG_FINISH, 8'h10),
             ACT_ACK, OWN_DIRECTED, 16'd510);
    row_want(pkt(KIND_PACKET, 32'd0, 16'd510, FLG_SYNC | FLG_RESET, 8'h10),
             ACT_ACK, OWN_DIRECTED, 16'd510);
    row_want(pkt(KIND_PACKET, OWN_DIRECTED, 16'd510, FLG_SYNC | FLG_FINISH, 8'h10),
             ACT_ACK, OWN_DIRECTED, 16'd510);
    // Reset from id zero while the own id is set: just an ack.
    row_want(pkt(KIND_PACKET, 32'd0, 16'd510, FLG_RESET, 8'h00), ACT_ACK, OWN_DIRECTED, 16'd510);
    // Foreign ids draw a reset back to them, whatever the flags.
    row_want(pkt(KIND_PACKET, 32'd1, 16'd510, FLG_RESET, 8'h00), ACT_RESET, 32'd1, 16'd0);
    row_want(pkt(KIND_PACKET, 32'hFFFF_FFFF, 16'd510, FLG_DATA, 8'hFF),
             ACT_RESET, 32'hFFFF_FFFF, 16'd0);
    row_want(pkt(KIND_PACKET, 32'h8000_0000, 16'd0, FLG_FINISH, 8'h00),
             ACT_RESET, 32'h8000_0000, 16'd0);
    // Timeout ignores every other field.
    row_want(pkt(KIND_TIMEOUT, 32'hFFFF_FFFF, 16'hFFFF, 3'h7, 8'hFF),
             ACT_ACK, OWN_DIRECTED, 16'd510);
    // Fill offsets one to six, then the head: a full eight-slot flush.
    row(pkt(KIND_PACKET, OWN_DIRECTED, 16'd765, FLG_DATA, 8'hAA));
    row(pkt(KIND_PACKET, 32'd0, 16'd1020, FLG_DATA, 8'h55));
    row(pkt(KIND_PACKET, OWN_DIRECTED, 16'd1275, FLG_DATA, 8'h7F));
    row(pkt(KIND_PACKET, 32'd0, 16'd1530, FLG_DATA, 8'h01));
    row(pkt(KIND_PACKET, OWN_DIRECTED, 16'd1785, FLG_DATA, 8'hFE));
    row(pkt(KIND_PACKET, 32'd0, 16'd2040, FLG_DATA, 8'h00));
    row(pkt(KIND_PACKET, OWN_DIRECTED, 16'd510, FLG_DATA, 8'h80));

    foreach (plan[i]) apply_event(plan[i].item, plan[i].typed, plan[i].want);

    // Sender mostly busy, receiver stalls often.
    random_phase(RAND_PER_PHASE);

    // Own id zero; sender idles often, receiver rarely stalls.
    drain();
    load_settings(32'd0, 4'd15);
    send_idle_pct  = 63;
    recv_stall_pct = 9;
    random_phase(RAND_PER_PHASE);

    // All-ones own id; both sides run flat out.
    drain();
    load_settings(32'hFFFF_FFFF, 4'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_phase(RAND_PER_PHASE);

    // Close the connection with a finish or an own reset, then show that
    // later items are swallowed without a result.
    drain();
    case ($urandom_range(3, 0))
      0:       last_reps = 4'd0;
      1:       last_reps = 4'd1;
      2:       last_reps = 4'd15;
      default: last_reps = 4'($urandom);
    endcase
    load_settings($urandom, last_reps);
    send_idle_pct  = 9;
    recv_stall_pct = 63;
    if ($urandom_range(1, 0))
      it = pkt(KIND_PACKET, $urandom_range(1, 0) ? own_conn : 32'd0, 16'($urandom),
               FLG_FINISH, 8'($urandom));
    else
      it = pkt(KIND_PACKET, own_conn, 16'($urandom), FLG_RESET, 8'($urandom));
    apply_event(it, 1'b0, '0);
    repeat (3) apply_event(random_event(), 1'b0, '0);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && predicted_actions.size() == 0) begin
      $display("selective_repeat_receive_window_top: match");
    end else begin
      $display("selective_repeat_receive_window_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- selective_repeat_receive_window_top.f -----
+incdir+rtl
rtl/srrw_pkg.sv
rtl/srrw_ctrl.sv
rtl/srrw_dp.sv
rtl/selective_repeat_receive_window_top.sv
tb/selective_repeat_receive_window_top_tb.sv
